// ===== rtl/dns_question_parser_assert.svh =====
// ----------------------------------------------------------------------------
// DNS question parser assertion macros
// Assertion macros shared by the parser RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DNS_QUESTION_PARSER_ASSERT_SVH
`define DNS_QUESTION_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked property, disabled while reset is held.
`define DQP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dns_question_parser assertion failed");

// Checked property that also holds during reset.
`define DQP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dns_question_parser assertion failed");

`else

`define DQP_ASSERT(lbl, prop)
`define DQP_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== rtl/dqp_pkg.sv =====
// ----------------------------------------------------------------------------
// DNS question parser package
// Shared types, result codes and the type and class mapping functions.
// ----------------------------------------------------------------------------
package dqp_pkg;

  // Saturation limit of the question byte count.
  localparam int MAX_QUESTION_BYTES = 511;
  localparam int COUNT_LIMIT_INT    = (MAX_QUESTION_BYTES < 511) ? MAX_QUESTION_BYTES : 511;
  localparam logic [8:0] COUNT_LIMIT = 9'(COUNT_LIMIT_INT);

  // Result kinds.
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_DOT  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Separator character.
  localparam logic [7:0] DOT_CHAR = 8'h2e;

  // Dense query type codes.
  localparam logic [2:0] TYPE_QUERY   = 3'd0;
  localparam logic [2:0] TYPE_IQUERY  = 3'd1;
  localparam logic [2:0] TYPE_STATUS  = 3'd2;
  localparam logic [2:0] TYPE_NOTIFY  = 3'd3;
  localparam logic [2:0] TYPE_UPDATE  = 3'd4;
  localparam logic [2:0] TYPE_UNKNOWN = 3'd5;

  // Dense query class codes.
  localparam logic [2:0] CLASS_INTERNET = 3'd0;
  localparam logic [2:0] CLASS_CSNET    = 3'd1;
  localparam logic [2:0] CLASS_CHAOS    = 3'd2;
  localparam logic [2:0] CLASS_HESIOD   = 3'd3;
  localparam logic [2:0] CLASS_NONE     = 3'd4;
  localparam logic [2:0] CLASS_ALL      = 3'd5;

  // Raw wire values of the type and class fields.
  localparam logic [15:0] RAW_0000 = 16'h0000;
  localparam logic [15:0] RAW_0001 = 16'h0001;
  localparam logic [15:0] RAW_0002 = 16'h0002;
  localparam logic [15:0] RAW_0003 = 16'h0003;
  localparam logic [15:0] RAW_0004 = 16'h0004;
  localparam logic [15:0] RAW_0005 = 16'h0005;
  localparam logic [15:0] RAW_00FE = 16'h00fe;
  localparam logic [15:0] RAW_00FF = 16'h00ff;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_NAME     = 3'd1,
    PH_TYPE_HI  = 3'd2,
    PH_TYPE_LO  = 3'd3,
    PH_CLASS_HI = 3'd4,
    PH_CLASS_LO = 3'd5
  } dqp_phase_t;

  // Input transaction payload.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       start_req;
  } dqp_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] name_char;
    logic [2:0] query_type_code;
    logic [2:0] query_class_code;
    logic [8:0] question_length;
  } dqp_out_t;

  // Map a raw query type to its dense code.
  function automatic logic [2:0] map_type(input logic [15:0] v);
    logic [2:0] code;
    case (v)
      RAW_0000: code = TYPE_QUERY;
      RAW_0001: code = TYPE_IQUERY;
      RAW_0002: code = TYPE_STATUS;
      RAW_0004: code = TYPE_NOTIFY;
      RAW_0005: code = TYPE_UPDATE;
      default:  code = TYPE_UNKNOWN;
    endcase
    return code;
  endfunction

  // Map a raw query class to its dense code; unknown classes give csnet.
  function automatic logic [2:0] map_class(input logic [15:0] v);
    logic [2:0] code;
    case (v)
      RAW_0001: code = CLASS_INTERNET;
      RAW_0002: code = CLASS_CSNET;
      RAW_0003: code = CLASS_CHAOS;
      RAW_0004: code = CLASS_HESIOD;
      RAW_00FE: code = CLASS_NONE;
      RAW_00FF: code = CLASS_ALL;
      default:  code = CLASS_CSNET;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/dqp_core.sv =====
// ----------------------------------------------------------------------------
// DNS question parser core
// Parser state and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
`include "dns_question_parser_assert.svh"

module dqp_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  dqp_pkg::dqp_in_t in_data,
  output logic             res_valid,
  output dqp_pkg::dqp_out_t res
);

  dqp_pkg::dqp_phase_t phase_r, phase_nxt;
  logic [7:0] label_position_r, label_position_nxt;
  logic [7:0] label_length_r, label_length_nxt;
  logic [7:0] type_high_byte_r, type_high_byte_nxt;
  logic [7:0] class_high_byte_r, class_high_byte_nxt;
  logic [8:0] byte_count_r, byte_count_nxt;
  logic [2:0] type_code_r, type_code_nxt;
  logic [8:0] count_inc;

  // Saturating increment of the byte count.
  assign count_inc = (byte_count_r < dqp_pkg::COUNT_LIMIT) ? byte_count_r + 9'd1
                                                            : byte_count_r;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= dqp_pkg::PH_IDLE;
      label_position_r  <= '0;
      label_length_r    <= '0;
      type_high_byte_r  <= '0;
      class_high_byte_r <= '0;
      byte_count_r      <= '0;
      type_code_r       <= '0;
    end else begin
      phase_r           <= phase_nxt;
      label_position_r  <= label_position_nxt;
      label_length_r    <= label_length_nxt;
      type_high_byte_r  <= type_high_byte_nxt;
      class_high_byte_r <= class_high_byte_nxt;
      byte_count_r      <= byte_count_nxt;
      type_code_r       <= type_code_nxt;
    end
  end

  // Next state and result for the accepted byte.
  always_comb begin
    phase_nxt           = phase_r;
    label_position_nxt  = label_position_r;
    label_length_nxt    = label_length_r;
    type_high_byte_nxt  = type_high_byte_r;
    class_high_byte_nxt = class_high_byte_r;
    byte_count_nxt      = byte_count_r;
    type_code_nxt       = type_code_r;
    res_valid           = 1'b0;
    res                 = '0;

    if (acc) begin
      if (in_data.start_req) begin
        // A start always opens a new question with this length byte.
        byte_count_nxt      = 9'd1;
        label_position_nxt  = '0;
        label_length_nxt    = in_data.byte_in;
        type_high_byte_nxt  = '0;
        class_high_byte_nxt = '0;
        type_code_nxt       = '0;
        phase_nxt = (in_data.byte_in == 8'd0) ? dqp_pkg::PH_TYPE_HI : dqp_pkg::PH_NAME;
      end else begin
        unique case (phase_r)
          dqp_pkg::PH_IDLE: begin
            // Stray bytes between questions are dropped.
          end
          dqp_pkg::PH_NAME: begin
            byte_count_nxt = count_inc;
            if (in_data.byte_in == 8'd0) begin
              phase_nxt = dqp_pkg::PH_TYPE_HI;
            end else if (label_position_r >= label_length_r) begin
              label_length_nxt   = in_data.byte_in;
              label_position_nxt = '0;
              res_valid          = 1'b1;
              res.kind           = dqp_pkg::KIND_DOT;
              res.name_char      = dqp_pkg::DOT_CHAR;
            end else begin
              label_position_nxt = label_position_r + 8'd1;
              res_valid          = 1'b1;
              res.kind           = dqp_pkg::KIND_CHAR;
              res.name_char      = in_data.byte_in;
            end
          end
          dqp_pkg::PH_TYPE_HI: begin
            byte_count_nxt     = count_inc;
            type_high_byte_nxt = in_data.byte_in;
            phase_nxt          = dqp_pkg::PH_TYPE_LO;
          end
          dqp_pkg::PH_TYPE_LO: begin
            byte_count_nxt = count_inc;
            type_code_nxt  = dqp_pkg::map_type({type_high_byte_r, in_data.byte_in});
            phase_nxt      = dqp_pkg::PH_CLASS_HI;
          end
          dqp_pkg::PH_CLASS_HI: begin
            byte_count_nxt      = count_inc;
            class_high_byte_nxt = in_data.byte_in;
            phase_nxt           = dqp_pkg::PH_CLASS_LO;
          end
          dqp_pkg::PH_CLASS_LO: begin
            byte_count_nxt       = count_inc;
            res_valid            = 1'b1;
            res.kind             = dqp_pkg::KIND_DONE;
            res.query_type_code  = type_code_r;
            res.query_class_code =
              dqp_pkg::map_class({class_high_byte_r, in_data.byte_in});
            res.question_length  = count_inc;
            phase_nxt            = dqp_pkg::PH_IDLE;
          end
          default: begin
            phase_nxt = dqp_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // The byte count never passes its saturation limit.
  `DQP_ASSERT(a_count_limit, byte_count_r <= dqp_pkg::COUNT_LIMIT)
  // A completed question returns the parser to idle.
  `DQP_ASSERT(a_done_idle, res_valid && res.kind == dqp_pkg::KIND_DONE |=> phase_r == dqp_pkg::PH_IDLE)
  // Name characters and dots come only from a non-start byte in the name.
  `DQP_ASSERT(a_name_src, res_valid && res.kind != dqp_pkg::KIND_DONE |-> phase_r == dqp_pkg::PH_NAME && !in_data.start_req)

endmodule

// ===== rtl/dns_question_parser.sv =====
// ----------------------------------------------------------------------------
// DNS question parser
// Streams a DNS question byte by byte and reports name text and codes.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle, back to back, and any result it causes
// appears in the output register on the next cycle. The only throttle is that
// output register: in_ready falls only while a result is held and out_ready is
// low. Name bytes give character results, later length bytes give dots, and
// the last class byte gives the completion result with type, class and length.
`include "dns_question_parser_assert.svh"

module dns_question_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dqp_pkg::dqp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dqp_pkg::dqp_out_t out_data
);

  logic              in_acc;
  logic              res_valid;
  dqp_pkg::dqp_out_t res;
  logic              out_valid_r, out_valid_nxt;
  dqp_pkg::dqp_out_t out_data_r;

  // A new transaction enters whenever the output register is free or draining.
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  dqp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .in_data  (in_data),
    .res_valid(res_valid),
    .res      (res)
  );

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A completed question always covers at least length byte, type and class.
  `DQP_ASSERT(a_done_len, out_valid && out_data.kind == dqp_pkg::KIND_DONE |-> out_data.question_length >= 9'd5)
  // An empty output register never blocks the input.
  `DQP_ASSERT(a_ready_free, !out_valid_r |-> in_ready)

endmodule
